/* rtl/cbf_pkg.sv */
// Shared constants for the cubic Bezier flatness test pipeline.
// No dependencies; imported by cbf_point and cubic_bezier_flatness_test.
package cbf_pkg;

    localparam int FRACTION_BITS = 16;
    // Reset threshold: round(0.0005 * 2^FRACTION_BITS)
    localparam logic [31:0] EPS_RESET =
        32'((((64'd1 << FRACTION_BITS) * 64'd5) + 64'd5000) / 64'd10000);

    localparam int COORD_W = 32;          // input coordinate width
    localparam int DIFF_W  = 33;          // coordinate difference
    localparam int PROD_W  = 66;          // product of two differences
    localparam int D2_W    = 66;          // squared distance / chord length
    localparam int NUM_W   = 132;         // squared cross product sum
    localparam int ROOT_W  = 33;          // integer square root of D2_W bits
    localparam int OUT_W   = 34;          // max_offset width

    localparam int DIV_STEPS  = D2_W;     // one quotient bit per stage
    localparam int SQRT_STEPS = ROOT_W;   // one root bit per stage
    // Register stages in one point unit: 5 front, divider, select, root
    localparam int PT_LAT = 5 + DIV_STEPS + 1 + SQRT_STEPS;

    localparam int IN_DATA_W  = 12 * COORD_W;
    localparam int OUT_DATA_W = 40;       // 35 bits of fields padded to bytes

endpackage

/* rtl/cubic_bezier_flatness_test.sv */
// Top level of the cubic Bezier flatness test: stream ports, threshold
// register, two point units, maximum and compare. Depends on cbf_pkg, cbf_point.
//
// Usage:
//   The slave stream carries one Bezier segment per transaction: four
//   signed Q16.16 control points. The master stream returns one transaction
//   per segment: the larger inner-point distance to the chord (max_offset,
//   unsigned, 34 bits) and is_flat, set when max_offset < flat_epsilon.
//   flat_epsilon is written through i_cfg_we / i_cfg_wdata; the user must
//   write it only while no segment is in flight (the block does not enforce
//   this). It resets to round(0.0005 * 2^16) = 33.
// Pipeline: 5 front stages (products and sums), 66 divider stages giving one
//   quotient bit each, a select stage, 33 square root stages, output stage.
// Throughput: unstalled, one segment per cycle; stages are plain registers.
// Reset: synchronous, clears all valid bits and reloads the threshold.
// Stall: while a result waits on the master side with m_axis_tready low,
//   the whole pipeline holds and s_axis_tready is low; nothing is lost or
//   repeated. A waiting result blocks input even when there are empty
//   stages ahead of it, since every stage shares the one enable.
module cubic_bezier_flatness_test
    import cbf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // start_x, start_y, start_z, ctrl_a_x .. ctrl_a_z, ctrl_b_x .. ctrl_b_z,
    // end_x, end_y, end_z: 32 bits each, lowest bits first
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // max_offset [33:0], is_flat [34], zero [39:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic [31:0]           i_cfg_wdata
);

    logic                      en;
    logic signed [COORD_W-1:0] pt [4][3];
    logic [ROOT_W-1:0]         dist_a;
    logic [ROOT_W-1:0]         dist_b;
    logic [OUT_W-1:0]          max_off;
    logic [31:0]               r_eps;
    logic [PT_LAT-1:0]         r_vld;
    logic                      r_out_valid;
    logic [OUT_W-1:0]          r_out_off;
    logic                      r_out_flat;

    // pipe advances unless the output register is full and stalled
    assign en            = !r_out_valid || m_axis_tready;
    assign s_axis_tready = en;

    // unpack the control points
    always_comb begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++)
                pt[i][j] = s_axis_tdata[(i*3+j)*COORD_W +: COORD_W];
    end

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_eps <= EPS_RESET;
        else if (i_cfg_we)
            r_eps <= i_cfg_wdata;
    end

    cbf_point u_point_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (pt[0]),
        .i_p    (pt[1]),
        .i_e    (pt[3]),
        .o_dist (dist_a)
    );

    cbf_point u_point_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_s    (pt[0]),
        .i_p    (pt[2]),
        .i_e    (pt[3]),
        .o_dist (dist_b)
    );

    // valid bits travel with the point unit stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[PT_LAT-2:0], s_axis_tvalid};
            r_out_valid <= r_vld[PT_LAT-1];
        end
    end

    // larger distance; a 33-bit root never reaches the 34-bit limit
    assign max_off = (dist_a > dist_b) ? OUT_W'(dist_a) : OUT_W'(dist_b);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_off  <= max_off;
            r_out_flat <= max_off < {2'b00, r_eps};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b00000, r_out_flat, r_out_off};

endmodule

/* rtl/cbf_point.sv */
// Pipelined distance of one inner control point to the chord P0-P3.
// Depends on cbf_pkg. Advances one stage per cycle while i_en is high.
module cbf_point
    import cbf_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_s [3],
    input  logic signed [COORD_W-1:0] i_p [3],
    input  logic signed [COORD_W-1:0] i_e [3],
    output logic        [ROOT_W-1:0]  o_dist
);

    // stage 1: differences
    logic signed [DIFF_W-1:0] r_v [3];
    logic signed [DIFF_W-1:0] r_w [3];
    logic signed [DIFF_W-1:0] r_we [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i]  <= {i_e[i][COORD_W-1], i_e[i]} - {i_s[i][COORD_W-1], i_s[i]};
                r_w[i]  <= {i_p[i][COORD_W-1], i_p[i]} - {i_s[i][COORD_W-1], i_s[i]};
                r_we[i] <= {i_p[i][COORD_W-1], i_p[i]} - {i_e[i][COORD_W-1], i_e[i]};
            end
        end
    end

    // stage 2: products, one 33x33 multiplier each
    logic signed [PROD_W-1:0] r_vw [3];
    logic signed [PROD_W-1:0] r_vv [3];
    logic signed [PROD_W-1:0] r_ww [3];
    logic signed [PROD_W-1:0] r_ee [3];
    logic signed [PROD_W-1:0] r_ca [3];
    logic signed [PROD_W-1:0] r_cb [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_vw[i] <= r_v[i] * r_w[i];
                r_vv[i] <= r_v[i] * r_v[i];
                r_ww[i] <= r_w[i] * r_w[i];
                r_ee[i] <= r_we[i] * r_we[i];
                r_ca[i] <= r_w[(i+1)%3] * r_v[(i+2)%3];
                r_cb[i] <= r_w[(i+2)%3] * r_v[(i+1)%3];
            end
        end
    end

    // stage 3: dot products, squared lengths, cross product magnitudes
    logic signed [PROD_W+1:0] r_c1;
    logic        [D2_W-1:0]   r_c2_3;
    logic        [D2_W-1:0]   r_dw;
    logic        [D2_W-1:0]   r_de;
    logic        [64:0]       r_cr [3];
    logic signed [PROD_W:0]   cr_diff [3];
    logic signed [PROD_W:0]   cr_abs [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr_diff[i] = {r_ca[i][PROD_W-1], r_ca[i]} - {r_cb[i][PROD_W-1], r_cb[i]};
            cr_abs[i]  = cr_diff[i][PROD_W] ? -cr_diff[i] : cr_diff[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1 <= {{2{r_vw[0][PROD_W-1]}}, r_vw[0]} + {{2{r_vw[1][PROD_W-1]}}, r_vw[1]}
                  + {{2{r_vw[2][PROD_W-1]}}, r_vw[2]};
            r_c2_3 <= D2_W'(r_vv[0]) + D2_W'(r_vv[1]) + D2_W'(r_vv[2]);
            r_dw   <= D2_W'(r_ww[0]) + D2_W'(r_ww[1]) + D2_W'(r_ww[2]);
            r_de   <= D2_W'(r_ee[0]) + D2_W'(r_ee[1]) + D2_W'(r_ee[2]);
            for (int i = 0; i < 3; i++)
                r_cr[i] <= cr_abs[i][64:0];
        end
    end

    // stage 4: region select and partial products of the cross squares
    logic              r_div_4;
    logic [D2_W-1:0]   r_dir_4;
    logic [D2_W-1:0]   r_c2_4;
    logic [65:0]       r_hh [3];
    logic [64:0]       r_hl [3];
    logic [63:0]       r_ll [3];
    logic              c1_le0;
    logic              c2_le_c1;

    assign c1_le0   = r_c1[PROD_W+1] || (r_c1 == '0);
    assign c2_le_c1 = $signed({2'b00, r_c2_3}) <= r_c1;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c2_4 <= r_c2_3;
            priority if (c1_le0) begin
                r_div_4 <= 1'b0;
                r_dir_4 <= r_dw;
            end else if (c2_le_c1) begin
                r_div_4 <= 1'b0;
                r_dir_4 <= r_de;
            end else begin
                r_div_4 <= 1'b1;
                r_dir_4 <= r_dw;
            end
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= r_cr[i][64:32] * r_cr[i][64:32];
                r_hl[i] <= r_cr[i][64:32] * r_cr[i][31:0];
                r_ll[i] <= r_cr[i][31:0] * r_cr[i][31:0];
            end
        end
    end

    // stage 5: squared cross product sum
    logic              r_div_5;
    logic [D2_W-1:0]   r_dir_5;
    logic [D2_W-1:0]   r_c2_5;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  num_sum;

    always_comb begin
        num_sum = '0;
        for (int i = 0; i < 3; i++)
            num_sum = num_sum + (NUM_W'(r_hh[i]) << 64) + (NUM_W'(r_hl[i]) << 33)
                    + NUM_W'(r_ll[i]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div_5 <= r_div_4;
            r_dir_5 <= r_dir_4;
            r_c2_5  <= r_c2_4;
            r_num   <= num_sum;
        end
    end

    // divider: one restoring step per stage, quotient shifts into r_b
    logic [D2_W-1:0] r_a   [DIV_STEPS];
    logic [D2_W-1:0] r_b   [DIV_STEPS];
    logic [D2_W-1:0] r_c2d [DIV_STEPS];
    logic [D2_W-1:0] r_dird[DIV_STEPS];
    logic            r_divd[DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [D2_W-1:0] a_in, b_in, c2_in, dir_in;
        logic            div_in;
        logic [D2_W:0]   t;
        logic            ge;

        if (k == 0) begin : g_first
            assign a_in   = r_num[NUM_W-1:D2_W];
            assign b_in   = r_num[D2_W-1:0];
            assign c2_in  = r_c2_5;
            assign dir_in = r_dir_5;
            assign div_in = r_div_5;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign c2_in  = r_c2d[k-1];
            assign dir_in = r_dird[k-1];
            assign div_in = r_divd[k-1];
        end

        assign t  = {a_in, b_in[D2_W-1]};
        assign ge = t >= {1'b0, c2_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a[k]    <= ge ? D2_W'(t - {1'b0, c2_in}) : t[D2_W-1:0];
                r_b[k]    <= {b_in[D2_W-2:0], ge};
                r_c2d[k]  <= c2_in;
                r_dird[k] <= dir_in;
                r_divd[k] <= div_in;
            end
        end
    end

    // squared distance for the chosen region
    logic [D2_W-1:0] r_x;

    always_ff @(posedge i_clk) begin
        if (i_en)
            r_x <= r_divd[DIV_STEPS-1] ? r_b[DIV_STEPS-1] : r_dird[DIV_STEPS-1];
    end

    // integer square root: two radicand bits per stage
    logic [ROOT_W+1:0] r_rr [SQRT_STEPS];
    logic [ROOT_W-1:0] r_rq [SQRT_STEPS];
    logic [D2_W-1:0]   r_rx [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [ROOT_W+1:0] r_in;
        logic [ROOT_W-1:0] q_in;
        logic [D2_W-1:0]   x_in;
        logic [ROOT_W+3:0] t;
        logic [ROOT_W+3:0] trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign r_in = '0;
            assign q_in = '0;
            assign x_in = r_x;
        end else begin : g_next
            assign r_in = r_rr[k-1];
            assign q_in = r_rq[k-1];
            assign x_in = r_rx[k-1];
        end

        assign t     = {r_in, x_in[D2_W-1:D2_W-2]};
        assign trial = {2'b00, q_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rr[k] <= ge ? (ROOT_W+2)'(t - trial) : t[ROOT_W+1:0];
                r_rq[k] <= {q_in[ROOT_W-2:0], ge};
                r_rx[k] <= {x_in[D2_W-3:0], 2'b00};
            end
        end
    end

    assign o_dist = r_rq[SQRT_STEPS-1];

endmodule
